>>> rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C register master: request codes,
// transaction kinds, sequencer phases and the request/result records.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Longest transfer; a larger request length saturates to this
  localparam int unsigned MaxLen = 256;

  // Request codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_DATA  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  // Transaction kinds
  typedef enum logic [1:0] {
    MODE_PROBE = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START1  = 4'd1,
    PH_TXADDRW = 4'd2,
    PH_TXREG   = 4'd3,
    PH_WAIT    = 4'd4,
    PH_TXDATA  = 4'd5,
    PH_START2  = 4'd6,
    PH_TXADDRR = 4'd7,
    PH_RX      = 4'd8,
    PH_RXACK   = 4'd9,
    PH_STOP    = 4'd10
  } phase_e;

  // Address byte direction bits
  localparam logic [7:0] AddrWrMask = 8'hFE;
  localparam logic [7:0] AddrRdBit  = 8'h01;

  // One request
  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] mode;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [8:0] length;
    logic [7:0] wr_byte;
    logic       sda_in;
  } item_t;

  // One result
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       data_request;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/i2c_register_master.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_master
// Bit-level I2C master for probe, register write and register read
// transactions; one tick request stands for one bit-delay period.
//
//   channel  direction  handshake               payload
//   request  in         in_valid_i / in_stall_o opcode, mode, addresses, length,
//                                               wr_byte, sda_in
//   result   out        out_valid_o/out_stall_i line levels, read byte, status
//
// One result per request; each passes the request register, then the result
// register. One request per cycle is sustained while the result is not stalled,
// set by the single-pass sequencer update between the two registers.
// Reset clears the sequencer to idle with both lines released.
// A stalled result holds; the request register keeps accepting until it fills.
// ----------------------------------------------------------------------------
module i2c_register_master (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [1:0] opcode_i,
  input  wire  [1:0] mode_i,
  input  wire  [7:0] dev_addr_i,
  input  wire  [7:0] reg_addr_i,
  input  wire  [8:0] length_i,
  input  wire  [7:0] wr_byte_i,
  input  wire        sda_in_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic [7:0] rd_byte_o,
  output logic       rd_valid_o,
  output logic       rd_last_o,
  output logic       data_request_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       status_o
);

  i2cm_pkg::item_t   item_q;
  i2cm_pkg::result_t res_d, res_q;
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic accept, adv;

  // Handshake: request moves on when the result register is free or draining
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = accept ? 1'b1 : (adv ? 1'b0 : in_valid_q);
    out_valid_d = adv ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.opcode   <= opcode_i;
      item_q.mode     <= mode_i;
      item_q.dev_addr <= dev_addr_i;
      item_q.reg_addr <= reg_addr_i;
      item_q.length   <= length_i;
      item_q.wr_byte  <= wr_byte_i;
      item_q.sda_in   <= sda_in_i;
    end
  end

  // Sequencer
  i2cm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_out_o      = res_q.scl_out;
  assign sda_out_o      = res_q.sda_out;
  assign rd_byte_o      = res_q.rd_byte;
  assign rd_valid_o     = res_q.rd_valid;
  assign rd_last_o      = res_q.rd_last;
  assign data_request_o = res_q.data_request;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign status_o       = res_q.status;

endmodule
`default_nettype wire

>>> rtl/i2cm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer state and its single-pass update: given the request that is
// advancing, computes the next line levels, counters and the result record.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 adv_i,
  input  wire i2cm_pkg::item_t item_i,
  output i2cm_pkg::result_t   res_o
);

  i2cm_pkg::phase_e phase_q, phase_d;
  logic [1:0] substep_q, substep_d;
  logic [3:0] bit_count_q, bit_count_d;
  logic [7:0] shift_q, shift_d;
  logic [8:0] byte_count_q, byte_count_d;
  logic [7:0] saved_addr_q, saved_addr_d;
  logic [7:0] saved_reg_q, saved_reg_d;
  logic [8:0] saved_len_q, saved_len_d;
  logic [1:0] saved_mode_q, saved_mode_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       nack_q, nack_d;

  logic [9:0] bc_inc;
  logic       is_last;
  logic [3:0] bit_inc;
  logic [7:0] rx_shift;
  logic [8:0] sat_len;

  assign bc_inc   = {1'b0, byte_count_q} + 10'd1;
  assign is_last  = (bc_inc == {1'b0, saved_len_q});
  assign bit_inc  = bit_count_q + 4'd1;
  assign rx_shift = {shift_q[6:0], item_i.sda_in};
  assign sat_len  = ({23'd0, item_i.length} > i2cm_pkg::MaxLen) ?
                    i2cm_pkg::MaxLen[8:0] : item_i.length;

  // Next state and result for the advancing request
  always_comb begin
    phase_d      = phase_q;
    substep_d    = substep_q;
    bit_count_d  = bit_count_q;
    shift_d      = shift_q;
    byte_count_d = byte_count_q;
    saved_addr_d = saved_addr_q;
    saved_reg_d  = saved_reg_q;
    saved_len_d  = saved_len_q;
    saved_mode_d = saved_mode_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    nack_d       = nack_q;
    res_o        = '0;

    case (i2cm_pkg::opcode_e'(item_i.opcode))
      i2cm_pkg::OP_BEGIN: begin
        if (phase_q == i2cm_pkg::PH_IDLE &&
            item_i.mode != i2cm_pkg::MODE_NONE) begin
          saved_mode_d = item_i.mode;
          saved_addr_d = item_i.dev_addr;
          saved_reg_d  = item_i.reg_addr;
          saved_len_d  = sat_len;
          byte_count_d = '0;
          nack_d       = 1'b0;
          bit_count_d  = '0;
          shift_d      = '0;
          phase_d      = i2cm_pkg::PH_START1;
          substep_d    = '0;
        end
      end
      i2cm_pkg::OP_DATA: begin
        if (phase_q == i2cm_pkg::PH_WAIT) begin
          phase_d     = i2cm_pkg::PH_TXDATA;
          shift_d     = item_i.wr_byte;
          bit_count_d = '0;
          substep_d   = '0;
        end
      end
      i2cm_pkg::OP_TICK: begin
        case (phase_q)
          // START and repeated START: SDA up, SCL up, SDA down, SCL down
          i2cm_pkg::PH_START1, i2cm_pkg::PH_START2: begin
            case (substep_q)
              2'd0: begin
                sda_d = 1'b1;
                substep_d = 2'd1;
              end
              2'd1: begin
                scl_d = 1'b1;
                substep_d = 2'd2;
              end
              2'd2: begin
                sda_d = 1'b0;
                substep_d = 2'd3;
              end
              default: begin
                scl_d       = 1'b0;
                bit_count_d = '0;
                substep_d   = '0;
                if (phase_q == i2cm_pkg::PH_START1) begin
                  phase_d = i2cm_pkg::PH_TXADDRW;
                  shift_d = saved_addr_q & i2cm_pkg::AddrWrMask;
                end else begin
                  phase_d = i2cm_pkg::PH_TXADDRR;
                  shift_d = saved_addr_q | i2cm_pkg::AddrRdBit;
                end
              end
            endcase
          end
          // Byte transmit: eight bits then the ACK slot
          i2cm_pkg::PH_TXADDRW, i2cm_pkg::PH_TXREG,
          i2cm_pkg::PH_TXDATA, i2cm_pkg::PH_TXADDRR: begin
            if (bit_count_q < 4'd8) begin
              case (substep_q)
                2'd0: begin
                  sda_d = shift_q[7];
                  substep_d = 2'd1;
                end
                2'd1: begin
                  scl_d = 1'b1;
                  substep_d = 2'd2;
                end
                default: begin
                  scl_d       = 1'b0;
                  shift_d     = {shift_q[6:0], 1'b0};
                  bit_count_d = bit_inc;
                  substep_d   = '0;
                end
              endcase
            end else begin
              case (substep_q)
                2'd0: begin
                  sda_d = 1'b1;
                  substep_d = 2'd1;
                end
                2'd1: begin
                  scl_d     = 1'b1;
                  nack_d    = item_i.sda_in;
                  substep_d = 2'd2;
                end
                default: begin
                  scl_d     = 1'b0;
                  substep_d = '0;
                  if (nack_q) begin
                    phase_d = i2cm_pkg::PH_STOP;
                  end else begin
                    case (phase_q)
                      i2cm_pkg::PH_TXADDRW: begin
                        if (saved_mode_q == i2cm_pkg::MODE_PROBE) begin
                          phase_d = i2cm_pkg::PH_STOP;
                        end else begin
                          phase_d     = i2cm_pkg::PH_TXREG;
                          shift_d     = saved_reg_q;
                          bit_count_d = '0;
                        end
                      end
                      i2cm_pkg::PH_TXREG: begin
                        if (saved_mode_q == i2cm_pkg::MODE_WRITE) begin
                          byte_count_d = '0;
                          phase_d = (saved_len_q != '0) ? i2cm_pkg::PH_WAIT :
                                                          i2cm_pkg::PH_STOP;
                        end else begin
                          phase_d = i2cm_pkg::PH_START2;
                        end
                      end
                      i2cm_pkg::PH_TXDATA: begin
                        byte_count_d = bc_inc[8:0];
                        phase_d = (bc_inc < {1'b0, saved_len_q}) ?
                                  i2cm_pkg::PH_WAIT : i2cm_pkg::PH_STOP;
                      end
                      default: begin
                        // address with read sent
                        byte_count_d = '0;
                        if (saved_len_q == '0) begin
                          phase_d = i2cm_pkg::PH_STOP;
                        end else begin
                          phase_d     = i2cm_pkg::PH_RX;
                          shift_d     = '0;
                          bit_count_d = '0;
                        end
                      end
                    endcase
                  end
                end
              endcase
            end
          end
          // Receive bit: SCL low with SDA released, then SCL up and sample
          i2cm_pkg::PH_RX: begin
            if (substep_q == 2'd0) begin
              scl_d     = 1'b0;
              sda_d     = 1'b1;
              substep_d = 2'd1;
            end else begin
              scl_d       = 1'b1;
              shift_d     = rx_shift;
              bit_count_d = bit_inc;
              substep_d   = '0;
              if (bit_inc >= 4'd8) begin
                res_o.rd_valid = 1'b1;
                res_o.rd_byte  = rx_shift;
                res_o.rd_last  = is_last;
                phase_d        = i2cm_pkg::PH_RXACK;
              end
            end
          end
          // Master ACK, or NACK on the last byte
          i2cm_pkg::PH_RXACK: begin
            case (substep_q)
              2'd0: begin
                scl_d     = 1'b0;
                sda_d     = is_last;
                substep_d = 2'd1;
              end
              2'd1: begin
                scl_d     = 1'b1;
                substep_d = 2'd2;
              end
              default: begin
                scl_d        = 1'b0;
                byte_count_d = bc_inc[8:0];
                substep_d    = '0;
                if (bc_inc >= {1'b0, saved_len_q}) begin
                  phase_d = i2cm_pkg::PH_STOP;
                end else begin
                  phase_d     = i2cm_pkg::PH_RX;
                  shift_d     = '0;
                  bit_count_d = '0;
                end
              end
            endcase
          end
          // STOP: SDA down, SCL up, SDA up
          i2cm_pkg::PH_STOP: begin
            case (substep_q)
              2'd0: begin
                sda_d = 1'b0;
                substep_d = 2'd1;
              end
              2'd1: begin
                scl_d = 1'b1;
                substep_d = 2'd2;
              end
              default: begin
                sda_d          = 1'b1;
                res_o.done_res = 1'b1;
                res_o.status   = nack_q;
                phase_d        = i2cm_pkg::PH_IDLE;
                substep_d      = '0;
              end
            endcase
          end
          default: begin
            // idle and waiting for data: lines hold
          end
        endcase
      end
      default: begin
      end
    endcase

    res_o.scl_out      = scl_d;
    res_o.sda_out      = sda_d;
    res_o.data_request = (phase_d == i2cm_pkg::PH_WAIT);
    res_o.busy_res     = (phase_d != i2cm_pkg::PH_IDLE);
  end

  // State registers, updated only when a request advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= i2cm_pkg::PH_IDLE;
      substep_q    <= '0;
      bit_count_q  <= '0;
      shift_q      <= '0;
      byte_count_q <= '0;
      saved_addr_q <= '0;
      saved_reg_q  <= '0;
      saved_len_q  <= '0;
      saved_mode_q <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      nack_q       <= 1'b0;
    end else if (adv_i) begin
      phase_q      <= phase_d;
      substep_q    <= substep_d;
      bit_count_q  <= bit_count_d;
      shift_q      <= shift_d;
      byte_count_q <= byte_count_d;
      saved_addr_q <= saved_addr_d;
      saved_reg_q  <= saved_reg_d;
      saved_len_q  <= saved_len_d;
      saved_mode_q <= saved_mode_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      nack_q       <= nack_d;
    end
  end

endmodule
`default_nettype wire
